// ===== rtl/dccpb_pkg.sv =====
package dccpb_pkg;

    // Command codes carried in the func field.
    localparam logic [2:0] CMD_ACQUIRE   = 3'd0;
    localparam logic [2:0] CMD_RELEASE   = 3'd1;
    localparam logic [2:0] CMD_SET_SPEED = 3'd2;
    localparam logic [2:0] CMD_IDLE      = 3'd3;
    localparam logic [2:0] CMD_ESTOP     = 3'd4;
    localparam logic [2:0] CMD_DIRECTION = 3'd5;
    localparam logic [2:0] CMD_FUNCTION  = 3'd6;

    // Locomotive limits.
    localparam int         NUM_FUNCS = 29;
    localparam logic [6:0] MAX_SPEED = 7'd126;
    localparam logic [4:0] MAX_FUNC  = 5'd28;

    // Function group boundaries, highest function number in each group.
    localparam logic [4:0] GRP1_LAST  = 5'd4;
    localparam logic [4:0] GRP2A_LAST = 5'd8;
    localparam logic [4:0] GRP2B_LAST = 5'd12;
    localparam logic [4:0] F13_LAST   = 5'd20;

    // Instruction and prefix codes of the DCC packet.
    localparam logic [7:0] SPEED_128_INSTR  = 8'h3F;
    localparam logic [1:0] LONG_ADDR_PREFIX = 2'b11;
    localparam logic [2:0] GRP1_PREFIX      = 3'b100;
    localparam logic [3:0] GRP2A_PREFIX     = 4'hB;
    localparam logic [3:0] GRP2B_PREFIX     = 4'hA;
    localparam logic [7:0] F13_F20_INSTR    = 8'hDE;
    localparam logic [7:0] F21_F28_INSTR    = 8'hDF;
    localparam logic [6:0] ESTOP_CODE       = 7'd1;

    // Packet buffer geometry.
    localparam int PKT_MAX_BYTES = 5;
    localparam int IDX_W         = $clog2(PKT_MAX_BYTES);

    // One throttle request as held in the command register.
    typedef struct packed {
        logic [2:0]  func;
        logic [13:0] loco_address;
        logic        long_form;
        logic [6:0]  speed_value;
        logic        direction_value;
        logic [4:0]  function_number;
        logic        function_on;
    } cmd_t;

    // Locomotive state held for the throttle.
    typedef struct packed {
        logic                 holding;
        logic [13:0]          held_address;
        logic                 is_long_form;
        logic [6:0]           speed_step;
        logic                 emergency_stop;
        logic                 forward;
        logic [NUM_FUNCS-1:0] function_bits;
    } loco_t;

    // One built packet: bytes in send order and the index of the check byte.
    typedef struct packed {
        logic [PKT_MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]              last_idx;
    } pkt_t;

endpackage

// ===== rtl/dcc_loco_packet_builder_core.sv =====
// DCC packet builder for one throttle. Each request on the input channel is
// a throttle command (acquire, release, set speed, idle, emergency stop,
// direction or function) that updates the held locomotive's state; with a
// locomotive held, speed, idle, emergency stop, direction and valid function
// commands then send one NMRA DCC packet on the output channel, one byte per
// request, with last_byte marking the XOR check byte. A request is held in
// the command register; a packet of 3 to 5 bytes then leaves from the packet
// buffer at one byte per cycle while out_ready is high. The next command is
// taken into the command register while the previous packet still drains.
module dcc_loco_packet_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [13:0] loco_address,
    input  logic        long_form,
    input  logic [6:0]  speed_value,
    input  logic        direction_value,
    input  logic [4:0]  function_number,
    input  logic        function_on,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packet_byte,
    output logic        last_byte
);
    import dccpb_pkg::*;

    cmd_t  cmd_reg;
    logic  cmd_valid_reg;
    logic  cmd_valid_next;
    logic  in_take;
    logic  cmd_apply;
    logic  pkt_load;
    logic  pkt_free;
    logic  emits;
    loco_t loco;
    loco_t loco_next;
    pkt_t  pkt;

    // Command register handshake: a command leaves once its packet has a slot.
    assign cmd_apply = cmd_valid_reg && (!emits || pkt_free);
    assign pkt_load  = cmd_valid_reg && emits && pkt_free;
    assign in_ready  = !cmd_valid_reg || cmd_apply;
    assign in_take   = in_valid && in_ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_apply)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg.func            <= func;
            cmd_reg.loco_address    <= loco_address;
            cmd_reg.long_form       <= long_form;
            cmd_reg.speed_value     <= speed_value;
            cmd_reg.direction_value <= direction_value;
            cmd_reg.function_number <= function_number;
            cmd_reg.function_on     <= function_on;
        end
    end

    // Locomotive state and command decode.
    dccpb_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_reg),
        .apply     (cmd_apply),
        .loco      (loco),
        .loco_next (loco_next),
        .emits     (emits)
    );

    // Packet assembly from the updated state.
    dccpb_build u_build (
        .loco (loco_next),
        .cmd  (cmd_reg),
        .pkt  (pkt)
    );

    // Packet buffer and byte output.
    dccpb_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt         (pkt),
        .load        (pkt_load),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .free        (pkt_free)
    );

    // The held speed step never exceeds the 128-step maximum.
    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        loco.speed_step <= MAX_SPEED)
        else $error("speed step above maximum");

    // An emergency stop always leaves the speed step at zero.
    a_estop_speed: assert property (@(posedge clk) disable iff (!rst_n)
        loco.emergency_stop |-> (loco.speed_step == '0))
        else $error("emergency stop with nonzero speed step");

    // After the check byte leaves with nothing new loaded, the output goes idle.
    a_pkt_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte && !pkt_load) |=> !out_valid)
        else $error("output still valid after final byte");

    // An applied acquire leaves a held locomotive running forward.
    a_acquire: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_apply && (cmd_reg.func == CMD_ACQUIRE)) |=> (loco.holding && loco.forward))
        else $error("acquire did not take the locomotive");

endmodule

// ===== rtl/dccpb_state.sv =====
module dccpb_state (
    input  logic            clk,
    input  logic            rst_n,
    input  dccpb_pkg::cmd_t cmd,
    input  logic            apply,
    output dccpb_pkg::loco_t loco,
    output dccpb_pkg::loco_t loco_next,
    output logic            emits
);
    import dccpb_pkg::*;

    // State after reset: nothing held, running forward.
    localparam loco_t LOCO_RESET = '{
        holding:        1'b0,
        held_address:   '0,
        is_long_form:   1'b0,
        speed_step:     '0,
        emergency_stop: 1'b0,
        forward:        1'b1,
        function_bits:  '0
    };

    loco_t loco_reg;

    // Apply one request to the locomotive state and flag whether a packet follows.
    always_comb
    begin
        loco_next = loco_reg;
        emits     = 1'b0;
        unique case (cmd.func)
            CMD_ACQUIRE:
            begin
                loco_next.holding        = 1'b1;
                loco_next.held_address   = cmd.loco_address;
                loco_next.is_long_form   = cmd.long_form;
                loco_next.speed_step     = '0;
                loco_next.emergency_stop = 1'b0;
                loco_next.forward        = 1'b1;
                loco_next.function_bits  = '0;
            end
            CMD_RELEASE:
            begin
                loco_next.holding      = 1'b0;
                loco_next.held_address = '0;
            end
            CMD_SET_SPEED:
            begin
                if (loco_reg.holding)
                begin
                    loco_next.speed_step = (cmd.speed_value > MAX_SPEED) ?
                                           MAX_SPEED : cmd.speed_value;
                    loco_next.emergency_stop = 1'b0;
                    emits = 1'b1;
                end
            end
            CMD_IDLE:
            begin
                if (loco_reg.holding)
                begin
                    loco_next.speed_step     = '0;
                    loco_next.emergency_stop = 1'b0;
                    emits = 1'b1;
                end
            end
            CMD_ESTOP:
            begin
                if (loco_reg.holding)
                begin
                    loco_next.speed_step     = '0;
                    loco_next.emergency_stop = 1'b1;
                    emits = 1'b1;
                end
            end
            CMD_DIRECTION:
            begin
                if (loco_reg.holding)
                begin
                    loco_next.forward = cmd.direction_value;
                    emits = 1'b1;
                end
            end
            CMD_FUNCTION:
            begin
                if (loco_reg.holding && (cmd.function_number <= MAX_FUNC))
                begin
                    loco_next.function_bits[cmd.function_number] = cmd.function_on;
                    emits = 1'b1;
                end
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
    end

    // State register; forward is set after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_reg <= LOCO_RESET;
        end
        else if (apply)
        begin
            loco_reg <= loco_next;
        end
    end

    assign loco = loco_reg;

endmodule

// ===== rtl/dccpb_build.sv =====
module dccpb_build (
    input  dccpb_pkg::loco_t loco,
    input  dccpb_pkg::cmd_t  cmd,
    output dccpb_pkg::pkt_t  pkt
);
    import dccpb_pkg::*;

    logic                 short_addr;
    logic                 two_body;
    logic                 is_function;
    logic [6:0]           speed_code;
    logic [7:0]           addr0;
    logic [7:0]           addr1;
    logic [7:0]           body0;
    logic [7:0]           body1;
    logic [7:0]           check;
    logic [NUM_FUNCS-1:0] f;

    assign f           = loco.function_bits;
    assign is_function = (cmd.func == CMD_FUNCTION);

    // Address bytes: one byte for a short address, two for the long form.
    assign short_addr = !loco.is_long_form && (loco.held_address[13:7] == '0);
    assign addr0 = short_addr ? {1'b0, loco.held_address[6:0]}
                              : {LONG_ADDR_PREFIX, loco.held_address[13:8]};
    assign addr1 = loco.held_address[7:0];

    // 128-step speed code; emergency stop overrides the step.
    always_comb
    begin
        if (loco.emergency_stop)
        begin
            speed_code = ESTOP_CODE;
        end
        else if (loco.speed_step == '0)
        begin
            speed_code = '0;
        end
        else
        begin
            speed_code = loco.speed_step + 7'd1;
        end
    end

    // Instruction bytes for a speed packet or the function group in question.
    always_comb
    begin
        body0    = SPEED_128_INSTR;
        body1    = {loco.forward, speed_code};
        two_body = 1'b1;
        if (is_function)
        begin
            if (cmd.function_number <= GRP1_LAST)
            begin
                body0    = {GRP1_PREFIX, f[0], f[4], f[3], f[2], f[1]};
                body1    = '0;
                two_body = 1'b0;
            end
            else if (cmd.function_number <= GRP2A_LAST)
            begin
                body0    = {GRP2A_PREFIX, f[8:5]};
                body1    = '0;
                two_body = 1'b0;
            end
            else if (cmd.function_number <= GRP2B_LAST)
            begin
                body0    = {GRP2B_PREFIX, f[12:9]};
                body1    = '0;
                two_body = 1'b0;
            end
            else if (cmd.function_number <= F13_LAST)
            begin
                body0 = F13_F20_INSTR;
                body1 = f[20:13];
            end
            else
            begin
                body0 = F21_F28_INSTR;
                body1 = f[28:21];
            end
        end
    end

    // XOR check over every byte that goes out before it.
    assign check = addr0 ^ (short_addr ? 8'h00 : addr1) ^ body0 ^ (two_body ? body1 : 8'h00);

    // Pack the bytes in send order.
    always_comb
    begin
        case ({short_addr, two_body})
            2'b10:
            begin
                pkt.bytes    = {8'h00, 8'h00, check, body0, addr0};
                pkt.last_idx = IDX_W'(2);
            end
            2'b11:
            begin
                pkt.bytes    = {8'h00, check, body1, body0, addr0};
                pkt.last_idx = IDX_W'(3);
            end
            2'b00:
            begin
                pkt.bytes    = {8'h00, check, body0, addr1, addr0};
                pkt.last_idx = IDX_W'(3);
            end
            default:
            begin
                pkt.bytes    = {check, body1, body0, addr1, addr0};
                pkt.last_idx = IDX_W'(4);
            end
        endcase
    end

endmodule

// ===== rtl/dccpb_ser.sv =====
module dccpb_ser (
    input  logic            clk,
    input  logic            rst_n,
    input  dccpb_pkg::pkt_t pkt,
    input  logic            load,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [7:0]      packet_byte,
    output logic            last_byte,
    output logic            free
);
    import dccpb_pkg::*;

    pkt_t             pkt_reg;
    logic             valid_reg;
    logic             valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // Current byte and end-of-packet mark.
    assign packet_byte = pkt_reg.bytes[idx_reg];
    assign last_byte   = (idx_reg == pkt_reg.last_idx);
    assign out_valid   = valid_reg;
    assign free        = !valid_reg || (out_ready && last_byte);

    // Advance through the packet one byte per accepted request.
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last_byte)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Packet buffer.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= pkt;
        end
    end

endmodule

// ===== test/loco_packet_checker.sv =====
// Watches both channels of the DCC packet builder, keeps its own copy of the
// locomotive state, predicts the packet bytes of every accepted throttle
// request and compares each returned byte with the oldest one predicted.
module loco_packet_checker
    import dccpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic [13:0] loco_address,
    input  logic        long_form,
    input  logic [6:0]  speed_value,
    input  logic        direction_value,
    input  logic [4:0]  function_number,
    input  logic        function_on,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output int          mismatch_count,
    output int          bytes_outstanding
);

    typedef struct {
        logic [7:0] value;
        logic       last;
    } packet_byte_t;

    // Predicted bytes in send order, oldest first.
    packet_byte_t expected_bytes[$];
    packet_byte_t oldest_byte;
    loco_t        loco;
    cmd_t         request;

    // Prefix the address, append the instruction bytes, close with the XOR
    // check byte and queue the whole packet.
    function automatic void queue_packet(input logic [7:0] instr0, input logic [7:0] instr1,
                                         input int instr_count);
        logic [7:0]   pkt [4];
        logic [7:0]   check_sum;
        packet_byte_t entry;
        int           len;
        int           k;
        len = 0;
        if (!loco.is_long_form && loco.held_address < 14'd128)
        begin
            pkt[0] = {1'b0, loco.held_address[6:0]};
            len = 1;
        end
        else
        begin
            pkt[0] = {LONG_ADDR_PREFIX, loco.held_address[13:8]};
            pkt[1] = loco.held_address[7:0];
            len = 2;
        end
        pkt[len] = instr0;
        len++;
        if (instr_count > 1)
        begin
            pkt[len] = instr1;
            len++;
        end
        check_sum = 8'h00;
        for (k = 0; k < len; k++)
        begin
            check_sum ^= pkt[k];
            entry.value = pkt[k];
            entry.last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), entry);
        end
        entry.value = check_sum;
        entry.last = 1'b1;
        expected_bytes.insert(expected_bytes.size(), entry);
    endfunction

    // A 128-step speed packet; an emergency stop overrides the speed step.
    function automatic void queue_speed_packet();
        logic [6:0] step_code;
        if (loco.emergency_stop)
            step_code = ESTOP_CODE;
        else if (loco.speed_step == 7'd0)
            step_code = 7'd0;
        else
            step_code = loco.speed_step + 7'd1;
        queue_packet(SPEED_128_INSTR, {loco.forward, step_code}, 2);
    endfunction

    // The function group packet that carries the given function.
    function automatic void queue_function_packet(input logic [4:0] number);
        logic [NUM_FUNCS-1:0] f;
        f = loco.function_bits;
        if (number <= GRP1_LAST)
            queue_packet({GRP1_PREFIX, f[0], f[4], f[3], f[2], f[1]}, 8'h00, 1);
        else if (number <= GRP2A_LAST)
            queue_packet({GRP2A_PREFIX, f[8:5]}, 8'h00, 1);
        else if (number <= GRP2B_LAST)
            queue_packet({GRP2B_PREFIX, f[12:9]}, 8'h00, 1);
        else if (number <= F13_LAST)
            queue_packet(F13_F20_INSTR, f[20:13], 2);
        else
            queue_packet(F21_F28_INSTR, f[28:21], 2);
    endfunction

    // Update the held locomotive for one throttle request and queue its packet, if it sends one.
    function automatic void apply_throttle_request(input cmd_t c);
        case (c.func)
            CMD_ACQUIRE:
            begin
                loco.holding = 1'b1;
                loco.held_address = c.loco_address;
                loco.is_long_form = c.long_form;
                loco.speed_step = 7'd0;
                loco.emergency_stop = 1'b0;
                loco.forward = 1'b1;
                loco.function_bits = '0;
            end
            CMD_RELEASE:
            begin
                loco.holding = 1'b0;
                loco.held_address = 14'd0;
            end
            default:
            begin
                // Without a held locomotive every other command is dropped.
                if (loco.holding)
                begin
                    case (c.func)
                        CMD_SET_SPEED:
                        begin
                            loco.speed_step = (c.speed_value > MAX_SPEED) ? MAX_SPEED
                                                                          : c.speed_value;
                            loco.emergency_stop = 1'b0;
                            queue_speed_packet();
                        end
                        CMD_IDLE:
                        begin
                            loco.speed_step = 7'd0;
                            loco.emergency_stop = 1'b0;
                            queue_speed_packet();
                        end
                        CMD_ESTOP:
                        begin
                            loco.speed_step = 7'd0;
                            loco.emergency_stop = 1'b1;
                            queue_speed_packet();
                        end
                        CMD_DIRECTION:
                        begin
                            loco.forward = c.direction_value;
                            queue_speed_packet();
                        end
                        CMD_FUNCTION:
                        begin
                            if (c.function_number <= MAX_FUNC)
                            begin
                                loco.function_bits[c.function_number] = c.function_on;
                                queue_function_packet(c.function_number);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    endfunction

    // Compare returned bytes first, since a request taken in the same cycle
    // cannot have produced any of them yet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco = '0;
            loco.forward = 1'b1;
            expected_bytes.delete();
            mismatch_count = 0;
            bytes_outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: packet byte %02h last %0b arrived with none expected",
                             $time, packet_byte, last_byte);
                    mismatch_count++;
                end
                else
                begin
                    oldest_byte = expected_bytes.pop_front();
                    if (packet_byte !== oldest_byte.value)
                    begin
                        $display("%0t: packet_byte expected %02h, got %02h",
                                 $time, oldest_byte.value, packet_byte);
                        mismatch_count++;
                    end
                    if (last_byte !== oldest_byte.last)
                    begin
                        $display("%0t: last_byte expected %0b, got %0b",
                                 $time, oldest_byte.last, last_byte);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                request = {func, loco_address, long_form, speed_value, direction_value,
                           function_number, function_on};
                apply_throttle_request(request);
            end
            bytes_outstanding = expected_bytes.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Drives throttle requests into the DCC packet builder under several sender
// and receiver pacing phases and reports the verdict of the packet checker.
module tb;
    import dccpb_pkg::*;

    // The one func code that the block leaves unused.
    localparam logic [2:0] CMD_UNUSED      = 3'd7;
    localparam int         RANDOM_REQUESTS = 420;
    localparam int         PHASE_REQUESTS  = 105;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         CYCLE_LIMIT     = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [13:0] loco_address;
    logic        long_form;
    logic [6:0]  speed_value;
    logic        direction_value;
    logic [4:0]  function_number;
    logic        function_on;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  packet_byte;
    logic        last_byte;

    int mismatch_count;
    int bytes_outstanding;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;
    bit loco_held = 1'b0;

    dcc_loco_packet_builder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .loco_address    (loco_address),
        .long_form       (long_form),
        .speed_value     (speed_value),
        .direction_value (direction_value),
        .function_number (function_number),
        .function_on     (function_on),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packet_byte     (packet_byte),
        .last_byte       (last_byte)
    );

    loco_packet_checker packet_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .loco_address      (loco_address),
        .long_form         (long_form),
        .speed_value       (speed_value),
        .direction_value   (direction_value),
        .function_number   (function_number),
        .function_on       (function_on),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .packet_byte       (packet_byte),
        .last_byte         (last_byte),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    // Clock with a period of 12.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random, at the rate of the current phase.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Give up if the run stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one request, with random idle cycles ahead of it, and hold it
    // until accepted. Called and left at a falling edge.
    task automatic send_request(input cmd_t r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func = r.func;
        loco_address = r.loco_address;
        long_form = r.long_form;
        speed_value = r.speed_value;
        direction_value = r.direction_value;
        function_number = r.function_number;
        function_on = r.function_on;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.func == CMD_ACQUIRE)
            loco_held = 1'b1;
        else if (r.func == CMD_RELEASE)
            loco_held = 1'b0;
        @(negedge clk);
    endtask

    task automatic send_command(input logic [2:0] f, input logic [13:0] addr,
                                input logic lf, input logic [6:0] spd, input logic dir,
                                input logic [4:0] fnum, input logic on);
        cmd_t r;
        r = {f, addr, lf, spd, dir, fnum, on};
        send_request(r);
    endtask

    // Hold off new requests until every predicted byte has come back.
    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (bytes_outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        cmd_t r;
        int   pick;
        int   n;

        rst_n = 1'b0;
        in_valid = 1'b0;
        func = CMD_ACQUIRE;
        loco_address = '0;
        long_form = 1'b0;
        speed_value = '0;
        direction_value = 1'b0;
        function_number = '0;
        function_on = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed requests: commands with no locomotive held, every command,
        // speed saturation, emergency stop repeated by a direction change,
        // each function group, ignored function numbers and the unused code.
        send_command(CMD_SET_SPEED, 14'd0, 1'b0, 7'd40, 1'b0, 5'd0, 1'b0);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b1);
        send_command(CMD_ACQUIRE, 14'd3, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_SET_SPEED, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_SET_SPEED, 14'd0, 1'b0, 7'd127, 1'b0, 5'd0, 1'b0);
        send_command(CMD_ESTOP, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_DIRECTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_IDLE, 14'd0, 1'b0, 7'd0, 1'b1, 5'd0, 1'b0);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd4, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd8, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd12, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd20, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd28, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd28, 1'b0);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd29, 1'b1);
        send_command(CMD_FUNCTION, 14'd0, 1'b0, 7'd0, 1'b0, 5'd31, 1'b1);
        send_command(CMD_UNUSED, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        // An address of 128 or more takes the long form even when short is asked.
        send_command(CMD_ACQUIRE, 14'd16383, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_SET_SPEED, 14'd0, 1'b0, 7'd126, 1'b0, 5'd0, 1'b0);
        send_command(CMD_ACQUIRE, 14'd127, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_DIRECTION, 14'd0, 1'b0, 7'd0, 1'b1, 5'd0, 1'b0);
        send_command(CMD_ACQUIRE, 14'd0, 1'b1, 7'd0, 1'b0, 5'd16, 1'b1);
        send_command(CMD_RELEASE, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);
        send_command(CMD_IDLE, 14'd0, 1'b0, 7'd0, 1'b0, 5'd0, 1'b0);

        // Random requests, mostly commands to a held locomotive, in four
        // pacing phases; each phase starts with the output fully drained.
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % PHASE_REQUESTS == 0)
            begin
                wait_for_drain();
                case (n / PHASE_REQUESTS)
                    0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                    1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
                    2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
                    default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
                endcase
            end
            r.func = 3'($urandom_range(7));
            r.loco_address = 14'($urandom_range(16383));
            r.long_form = 1'($urandom_range(1));
            r.speed_value = 7'($urandom_range(127));
            r.direction_value = 1'($urandom_range(1));
            r.function_number = 5'($urandom_range(31));
            r.function_on = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (!loco_held && pick < 85)
                r.func = CMD_ACQUIRE;
            else if (pick < 4)
                r.func = CMD_ACQUIRE;
            else if (pick < 7)
                r.func = CMD_RELEASE;
            else if (pick < 9)
                r.func = CMD_UNUSED;
            else if (pick < 30)
                r.func = CMD_SET_SPEED;
            else if (pick < 37)
                r.func = CMD_IDLE;
            else if (pick < 44)
                r.func = CMD_ESTOP;
            else if (pick < 54)
                r.func = CMD_DIRECTION;
            else
                r.func = CMD_FUNCTION;
            // Keep many addresses in short range and most function numbers valid.
            if ($urandom_range(1) == 0)
                r.loco_address = 14'($urandom_range(127));
            if ($urandom_range(9) != 0)
                r.function_number = 5'($urandom_range(MAX_FUNC));
            send_request(r);
        end

        // Let every packet leave, then keep watching for strays before the verdict.
        receiver_stall_pct = 0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
